FILE: src/dch_pkg.sv
// Shared types and codes of the distinct color histogram.
`default_nettype none
package dch_pkg;

	typedef enum logic [1:0] {
		FUNC_CLEAR = 2'd0,
		FUNC_ADD   = 2'd1,
		FUNC_READ  = 2'd2,
		FUNC_NOP   = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		STATUS_OK        = 2'd0,
		STATUS_OVERFLOW  = 2'd1,
		STATUS_BAD_INDEX = 2'd2
	} status_t;

	// Control part of the command beat that walks down the row of cells.
	typedef struct packed {
		logic        vld;
		func_t       func;
		logic        active;   // add still takes part (table not yet overflowed)
		logic        room;     // a miss may append a new entry
		logic [7:0]  ridx;
		logic        hit;      // some cell has already answered
		logic        appended; // the answering cell took a new entry
	} ctl_t;

endpackage
`default_nettype wire

FILE: src/dch_cell.sv
// One palette entry of the histogram row, with its stage of the command pipeline.
`default_nettype none
module dch_cell import dch_pkg::*; #(
	parameter int COLOR_BITS = 32,
	parameter int COUNT_BITS = 24,
	parameter int IDX_W      = 8,
	parameter int USED_W     = 9
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic [IDX_W-1:0]      cell_idx,
	input  wire ctl_t                  ctl_in,
	input  wire logic [COLOR_BITS-1:0] color_in,
	input  wire logic [USED_W-1:0]     used_in,
	input  wire logic [IDX_W-1:0]      hit_idx_in,
	input  wire logic [COLOR_BITS-1:0] hit_color_in,
	input  wire logic [COUNT_BITS-1:0] hit_count_in,
	output ctl_t                       ctl_out,
	output logic [COLOR_BITS-1:0]      color_out,
	output logic [USED_W-1:0]          used_out,
	output logic [IDX_W-1:0]           hit_idx_out,
	output logic [COLOR_BITS-1:0]      hit_color_out,
	output logic [COUNT_BITS-1:0]      hit_count_out
);

	logic [COLOR_BITS-1:0] color_q;
	logic [COUNT_BITS-1:0] count_q;

	ctl_t                  ctl_q, ctl_nxt;
	logic [COLOR_BITS-1:0] pass_color_q, hit_color_q, hit_color_nxt;
	logic [USED_W-1:0]     used_q;
	logic [IDX_W-1:0]      hit_idx_q, hit_idx_nxt;
	logic [COUNT_BITS-1:0] hit_count_q, hit_count_nxt, count_inc;
	logic                  in_use, is_next, wr_match, wr_new;

	always_comb begin
		in_use    = USED_W'(cell_idx) < used_in;
		is_next   = USED_W'(cell_idx) == used_in;
		count_inc = (&count_q) ? count_q : count_q + COUNT_BITS'(1);
		ctl_nxt       = ctl_in;
		hit_idx_nxt   = hit_idx_in;
		hit_color_nxt = hit_color_in;
		hit_count_nxt = hit_count_in;
		wr_match      = 1'b0;
		wr_new        = 1'b0;
		if (ctl_in.vld && !ctl_in.hit) begin
			case (ctl_in.func)
				FUNC_ADD: begin
					if (ctl_in.active && in_use && color_q == color_in) begin
						wr_match      = 1'b1;
						ctl_nxt.hit   = 1'b1;
						hit_idx_nxt   = cell_idx;
						hit_color_nxt = color_q;
						hit_count_nxt = count_inc;
					end else if (ctl_in.active && is_next && ctl_in.room) begin
						wr_new           = 1'b1;
						ctl_nxt.hit      = 1'b1;
						ctl_nxt.appended = 1'b1;
						hit_idx_nxt      = cell_idx;
						hit_color_nxt    = color_in;
						hit_count_nxt    = COUNT_BITS'(1);
					end
				end
				FUNC_READ: begin
					if (in_use && 16'(ctl_in.ridx) == 16'(cell_idx)) begin
						ctl_nxt.hit   = 1'b1;
						hit_idx_nxt   = cell_idx;
						hit_color_nxt = color_q;
						hit_count_nxt = count_q;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Entry storage: written only by an add, so it needs no reset.
	always_ff @(posedge clk) begin
		if (wr_new) begin
			color_q <= color_in;
			count_q <= COUNT_BITS'(1);
		end else if (wr_match) begin
			count_q <= count_inc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else begin
			ctl_q <= ctl_nxt;
		end
	end

	always_ff @(posedge clk) begin
		pass_color_q <= color_in;
		used_q       <= used_in;
		hit_idx_q    <= hit_idx_nxt;
		hit_color_q  <= hit_color_nxt;
		hit_count_q  <= hit_count_nxt;
	end

	assign ctl_out       = ctl_q;
	assign color_out     = pass_color_q;
	assign used_out      = used_q;
	assign hit_idx_out   = hit_idx_q;
	assign hit_color_out = hit_color_q;
	assign hit_count_out = hit_count_q;

endmodule
`default_nettype wire

FILE: src/distinct_color_histogram_core.sv
// Top level of the distinct color histogram: command port, row of entry cells and totals.
`default_nettype none
// The palette is a row of MAX_ENTRIES cells, one entry each. A command beat
// (clear, add, read or no-op) is taken when start is high and busy is low;
// it then walks down the row one cell per clock, each cell comparing the
// colour with its own entry. done is registered from the beat leaving the last
// cell and stays high for exactly one cycle, during which the result beat
// is on the result ports. busy stays high while the beat is in the row and
// drops at the same edge at which done rises, so the block takes no new
// command before the last one is through; a new command may be issued in
// the cycle in which done is high. The receiver cannot stall: a result
// beat is presented once and is lost if not taken. There is no clearing
// pass after reset; the table starts empty.
// max_colors is written through cfg_we and cfg_wdata and should only be
// changed while busy is low; its reset value is 256.
module distinct_color_histogram_core import dch_pkg::*; #(
	parameter int MAX_ENTRIES = 256,
	parameter int COLOR_BITS  = 32,
	parameter int COUNT_BITS  = 24
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [1:0]  func,
	input  wire logic [31:0] pixel_color,
	input  wire logic [7:0]  read_index,
	input  wire logic        cfg_we,
	input  wire logic [8:0]  cfg_wdata,
	output logic             done,
	output logic [1:0]       status,
	output logic [7:0]       entry_index,
	output logic [31:0]      entry_color,
	output logic [23:0]      entry_count,
	output logic [8:0]       distinct_count,
	output logic [23:0]      pixel_total
);

	localparam int IDX_W  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int USED_W = $clog2(MAX_ENTRIES + 1);

	// Block state.
	logic [8:0]            max_colors_q;
	logic [USED_W-1:0]     used_q;
	logic [COUNT_BITS-1:0] pixels_q;
	logic                  ovf_q;
	logic                  busy_q;

	// Result registers.
	logic        done_q;
	status_t     status_q;
	logic [7:0]  entry_index_q;
	logic [31:0] entry_color_q;
	logic [23:0] entry_count_q;
	logic [8:0]  distinct_q;
	logic [23:0] total_q;

	// The chain between cells; element k feeds cell k.
	ctl_t                  ctl_c       [MAX_ENTRIES+1];
	logic [COLOR_BITS-1:0] color_c     [MAX_ENTRIES+1];
	logic [USED_W-1:0]     used_c      [MAX_ENTRIES+1];
	logic [IDX_W-1:0]      hit_idx_c   [MAX_ENTRIES+1];
	logic [COLOR_BITS-1:0] hit_color_c [MAX_ENTRIES+1];
	logic [COUNT_BITS-1:0] hit_count_c [MAX_ENTRIES+1];

	logic              accept;
	logic [USED_W-1:0] limit;
	ctl_t              last;

	assign accept = start && !busy_q;

	// The limit in force is the smaller of max_colors and the row length.
	always_comb begin
		if (32'(max_colors_q) < MAX_ENTRIES) begin
			limit = USED_W'(max_colors_q);
		end else begin
			limit = USED_W'(MAX_ENTRIES);
		end
	end

	// The command enters cell 0 straight from the ports at the accepting edge.
	always_comb begin
		ctl_c[0].vld      = accept;
		ctl_c[0].func     = func_t'(func);
		ctl_c[0].active   = !ovf_q;
		ctl_c[0].room     = used_q < limit;
		ctl_c[0].ridx     = read_index;
		ctl_c[0].hit      = 1'b0;
		ctl_c[0].appended = 1'b0;
	end
	assign color_c[0]     = pixel_color[COLOR_BITS-1:0];
	assign used_c[0]      = used_q;
	assign hit_idx_c[0]   = '0;
	assign hit_color_c[0] = '0;
	assign hit_count_c[0] = '0;

	for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
		dch_cell #(
			.COLOR_BITS(COLOR_BITS),
			.COUNT_BITS(COUNT_BITS),
			.IDX_W     (IDX_W),
			.USED_W    (USED_W)
		) u_cell (
			.clk          (clk),
			.arst_n       (arst_n),
			.cell_idx     (IDX_W'(i)),
			.ctl_in       (ctl_c[i]),
			.color_in     (color_c[i]),
			.used_in      (used_c[i]),
			.hit_idx_in   (hit_idx_c[i]),
			.hit_color_in (hit_color_c[i]),
			.hit_count_in (hit_count_c[i]),
			.ctl_out      (ctl_c[i+1]),
			.color_out    (color_c[i+1]),
			.used_out     (used_c[i+1]),
			.hit_idx_out  (hit_idx_c[i+1]),
			.hit_color_out(hit_color_c[i+1]),
			.hit_count_out(hit_count_c[i+1])
		);
	end

	assign last = ctl_c[MAX_ENTRIES];

	// Closing a command: the beat leaving the last cell updates the totals and
	// forms the result. Totals reported after an add are the updated ones.
	logic [USED_W-1:0]     used_nxt;
	logic [COUNT_BITS-1:0] pixels_nxt, pixels_inc;
	logic                  ovf_nxt;
	status_t               status_nxt;
	logic [7:0]            index_nxt;
	logic [31:0]           color_nxt, hit_count_w, pixels_w;
	logic [COUNT_BITS-1:0] count_nxt;
	logic                  totals;

	always_comb begin
		pixels_inc = (&pixels_q) ? pixels_q : pixels_q + COUNT_BITS'(1);
		used_nxt   = used_q;
		pixels_nxt = pixels_q;
		ovf_nxt    = ovf_q;
		status_nxt = ovf_q ? STATUS_OVERFLOW : STATUS_OK;
		index_nxt  = '0;
		color_nxt  = '0;
		count_nxt  = '0;
		totals     = 1'b1;
		case (last.func)
			FUNC_CLEAR: begin
				used_nxt   = '0;
				pixels_nxt = '0;
				ovf_nxt    = 1'b0;
				status_nxt = STATUS_OK;
				totals     = 1'b0;
			end
			FUNC_ADD: begin
				if (!last.active) begin
					status_nxt = STATUS_OVERFLOW;
				end else if (last.hit) begin
					status_nxt = STATUS_OK;
					pixels_nxt = pixels_inc;
					if (last.appended) begin
						used_nxt = used_q + USED_W'(1);
					end
					index_nxt = 8'(hit_idx_c[MAX_ENTRIES]);
					color_nxt = 32'(hit_color_c[MAX_ENTRIES]);
					count_nxt = hit_count_c[MAX_ENTRIES];
				end else begin
					// A miss on a full table.
					ovf_nxt    = 1'b1;
					status_nxt = STATUS_OVERFLOW;
				end
			end
			FUNC_READ: begin
				index_nxt = last.ridx;
				if (last.hit) begin
					color_nxt = 32'(hit_color_c[MAX_ENTRIES]);
					count_nxt = hit_count_c[MAX_ENTRIES];
				end else begin
					status_nxt = STATUS_BAD_INDEX;
				end
			end
			default: begin
			end
		endcase
		hit_count_w = 32'(count_nxt);
		pixels_w    = 32'(pixels_nxt);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_colors_q <= 9'd256;
			used_q       <= '0;
			pixels_q     <= '0;
			ovf_q        <= 1'b0;
			busy_q       <= 1'b0;
			done_q       <= 1'b0;
		end else begin
			if (cfg_we) begin
				max_colors_q <= cfg_wdata;
			end
			done_q <= last.vld;
			if (accept) begin
				busy_q <= 1'b1;
			end else if (last.vld) begin
				busy_q <= 1'b0;
			end
			if (last.vld) begin
				used_q   <= used_nxt;
				pixels_q <= pixels_nxt;
				ovf_q    <= ovf_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (last.vld) begin
			status_q      <= status_nxt;
			entry_index_q <= index_nxt;
			entry_color_q <= color_nxt;
			entry_count_q <= hit_count_w[23:0];
			distinct_q    <= totals ? 9'(32'(used_nxt)) : 9'd0;
			total_q       <= totals ? pixels_w[23:0] : 24'd0;
		end
	end

	assign busy           = busy_q;
	assign done           = done_q;
	assign status         = status_q;
	assign entry_index    = entry_index_q;
	assign entry_color    = entry_color_q;
	assign entry_count    = entry_count_q;
	assign distinct_count = distinct_q;
	assign pixel_total    = total_q;

	// A result beat only follows a command that was in flight.
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q))
		else $error("result beat without a command in flight");

	// The beat leaving the row always belongs to a command in flight.
	a_last_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		last.vld |-> busy_q)
		else $error("command beat left the row while idle");

	// A taken command holds the block busy on the next cycle.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy_q)
		else $error("busy not raised after a command was taken");

	// The table never holds more entries than there are cells.
	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(used_q) <= MAX_ENTRIES)
		else $error("entry count beyond the row length");

	// An append can only happen where the table had room.
	a_append_room: assert property (@(posedge clk) disable iff (!arst_n)
		(last.vld && last.appended) |-> last.room)
		else $error("entry appended to a full table");

endmodule
`default_nettype wire

FILE: verif/testbench.sv
// Self-checking testbench for the distinct color histogram core.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import dch_pkg::*;

	// Commands walk the whole cell row before answering, and random sender
	// gaps of up to GAP_MAX are added on top of that. Even a run with every
	// gap at its longest stays far inside this limit.
	localparam int CYCLE_LIMIT = 3_000_000;
	localparam int GAP_MAX     = 270;
	localparam int DRAIN_WAIT  = 300;
	localparam int RANDOM_GOAL = 1500;

	typedef enum logic [1:0] {
		JOB_CMD,   // one command beat on the start/busy port
		JOB_CFG,   // a max_colors write, issued only once the core is idle
		JOB_HOLD   // stall the sender until every expected answer is back
	} job_kind_t;

	typedef struct {
		job_kind_t   kind;
		func_t       op;
		logic [31:0] color;
		logic [7:0]  ridx;
		logic [8:0]  limit;
		int          idle_pct;
	} palette_job_t;

	typedef struct packed {
		status_t     status;
		logic [7:0]  idx;
		logic [31:0] color;
		logic [23:0] count;
		logic [8:0]  distinct;
		logic [23:0] total;
	} palette_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic [1:0]  func = FUNC_NOP;
	logic [31:0] pixel_color = '0;
	logic [7:0]  read_index = '0;
	logic        cfg_we = 1'b0;
	logic [8:0]  cfg_wdata = '0;
	logic        busy;
	logic        done;
	logic [1:0]  status;
	logic [7:0]  entry_index;
	logic [31:0] entry_color;
	logic [23:0] entry_count;
	logic [8:0]  distinct_count;
	logic [23:0] pixel_total;

	distinct_color_histogram_core dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.func           (func),
		.pixel_color    (pixel_color),
		.read_index     (read_index),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.done           (done),
		.status         (status),
		.entry_index    (entry_index),
		.entry_color    (entry_color),
		.entry_count    (entry_count),
		.distinct_count (distinct_count),
		.pixel_total    (pixel_total)
	);

	always #5 clk = ~clk;

	// Our own copy of the palette. Only entries below pal_used are ever looked
	// at, so the stale contents left behind by a clear never matter.
	logic [31:0] pal_color [256];
	logic [23:0] pal_count [256];
	int          pal_used = 0;
	logic [23:0] pal_seen = '0;
	bit          pal_ovf = 1'b0;
	logic [8:0]  limit_setting = 9'd256;

	palette_job_t    job_q[$];
	palette_result_t palette_expect_q[$];

	int beats_issued = 0;
	int results_seen = 0;
	int mismatch_cnt = 0;
	int cycle_cnt = 0;
	int gap_left = 0;
	int cur_gap_pct = 0;
	int cur_pct = 36;

	// Coverage tallies for the closing summary.
	int n_add = 0, n_read = 0, n_clear = 0, n_nop = 0, n_cfg = 0;
	int n_hit = 0, n_append = 0, n_ovf = 0, n_bad_read = 0;

	function automatic logic [23:0] count_bump(logic [23:0] v);
		return (v == '1) ? v : v + 24'd1;
	endfunction

	// Works out the answer to one command beat and updates the palette copy.
	function automatic palette_result_t histogram_predict(func_t op, logic [31:0] pix,
			logic [7:0] ridx);
		palette_result_t r;
		int lim;
		int hit;
		int i;
		r = '0;
		lim = (limit_setting < 9'd256) ? int'(limit_setting) : 256;
		case (op)
		FUNC_CLEAR: begin
			n_clear++;
			pal_used = 0;
			pal_seen = '0;
			pal_ovf = 1'b0;
		end
		FUNC_ADD: begin
			n_add++;
			if (pal_ovf) begin
				// Once the table has overflowed, adds are ignored until a clear.
				r.status = STATUS_OVERFLOW;
				n_ovf++;
			end else begin
				hit = -1;
				for (i = 0; i < pal_used; i++)
					if (hit < 0 && pal_color[i] == pix)
						hit = i;
				if (hit >= 0) begin
					pal_count[hit] = count_bump(pal_count[hit]);
					pal_seen = count_bump(pal_seen);
					r.idx = 8'(hit);
					r.color = pix;
					r.count = pal_count[hit];
					n_hit++;
				end else if (pal_used >= lim) begin
					// A miss on a full table sets the sticky flag and is not counted.
					pal_ovf = 1'b1;
					r.status = STATUS_OVERFLOW;
					n_ovf++;
				end else begin
					pal_color[pal_used] = pix;
					pal_count[pal_used] = 24'd1;
					r.idx = 8'(pal_used);
					r.color = pix;
					r.count = 24'd1;
					pal_used++;
					pal_seen = count_bump(pal_seen);
					n_append++;
				end
			end
		end
		FUNC_READ: begin
			n_read++;
			r.idx = ridx;
			if (int'(ridx) < pal_used) begin
				r.status = pal_ovf ? STATUS_OVERFLOW : STATUS_OK;
				r.color = pal_color[ridx];
				r.count = pal_count[ridx];
			end else begin
				r.status = STATUS_BAD_INDEX;
				n_bad_read++;
			end
		end
		default: begin
			n_nop++;
			r.status = pal_ovf ? STATUS_OVERFLOW : STATUS_OK;
		end
		endcase
		// A clear reports zero totals; everything else reports them after the update.
		if (op != FUNC_CLEAR) begin
			r.distinct = 9'(pal_used);
			r.total = pal_seen;
		end
		return r;
	endfunction

	task automatic flag_mismatch(string what);
		mismatch_cnt++;
		if (mismatch_cnt <= 100)
			$display("MISMATCH at result beat %0d (t=%0t): %s", results_seen, $time, what);
	endtask

	task automatic queue_job(job_kind_t kind, func_t op, logic [31:0] color,
			logic [7:0] ridx, logic [8:0] limit);
		palette_job_t j;
		j.kind = kind;
		j.op = op;
		j.color = color;
		j.ridx = ridx;
		j.limit = limit;
		j.idle_pct = cur_pct;
		job_q.push_back(j);
	endtask

	// Driver. A beat is taken at an edge where start is high and busy is low;
	// the prediction is made at that same edge, so it sees the commands in the
	// order in which the core takes them. After each beat the sender may hold
	// back for a random stretch, which lands the next start at any point of
	// the busy window or after it. Each signal gets one assignment per edge.
	always @(posedge clk) begin : driver
		palette_job_t nxt;
		logic nxt_start;
		logic nxt_we;
		if (arst_n) begin
			if (cfg_we) begin
				limit_setting = cfg_wdata;
				n_cfg++;
			end
			if (start && !busy) begin
				palette_expect_q.push_back(histogram_predict(func_t'(func), pixel_color,
					read_index));
				beats_issued++;
				if ($urandom_range(99) < cur_gap_pct)
					gap_left = $urandom_range(GAP_MAX, 1);
			end
			if (!(start && busy)) begin
				nxt_start = 1'b0;
				nxt_we = 1'b0;
				if (gap_left > 0) begin
					gap_left--;
				end else if (job_q.size() != 0) begin
					case (job_q[0].kind)
					JOB_CMD: begin
						nxt = job_q.pop_front();
						func <= nxt.op;
						pixel_color <= nxt.color;
						read_index <= nxt.ridx;
						cur_gap_pct = nxt.idle_pct;
						nxt_start = 1'b1;
					end
					JOB_CFG: begin
						// The register only changes while nothing is in flight.
						if (beats_issued == results_seen) begin
							nxt = job_q.pop_front();
							cfg_wdata <= nxt.limit;
							nxt_we = 1'b1;
						end
					end
					default: begin
						if (beats_issued == results_seen)
							void'(job_q.pop_front());
					end
					endcase
				end
				start <= nxt_start;
				cfg_we <= nxt_we;
			end
		end
	end

	// Monitor. The result is valid for the single cycle in which done is high
	// and is sampled at the edge that ends that cycle. results_seen moves with
	// a nonblocking update, so the driver always reads the count from before
	// the edge.
	always @(posedge clk) begin : monitor
		palette_result_t want;
		if (arst_n && done === 1'b1) begin
			results_seen <= results_seen + 1;
			if (palette_expect_q.size() == 0) begin
				flag_mismatch("result beat with nothing expected");
			end else begin
				want = palette_expect_q.pop_front();
				if (status !== want.status)
					flag_mismatch($sformatf("status %0d, expected %0d", status, want.status));
				if (entry_index !== want.idx)
					flag_mismatch($sformatf("entry_index %0d, expected %0d",
						entry_index, want.idx));
				if (entry_color !== want.color)
					flag_mismatch($sformatf("entry_color %h, expected %h",
						entry_color, want.color));
				if (entry_count !== want.count)
					flag_mismatch($sformatf("entry_count %0d, expected %0d",
						entry_count, want.count));
				if (distinct_count !== want.distinct)
					flag_mismatch($sformatf("distinct_count %0d, expected %0d",
						distinct_count, want.distinct));
				if (pixel_total !== want.total)
					flag_mismatch($sformatf("pixel_total %0d, expected %0d",
						pixel_total, want.total));
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("Timed out after %0d cycles with %0d beats still unanswered",
				cycle_cnt, beats_issued - results_seen);
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		logic [31:0] pool [32];
		int          pool_n;
		int          rand_items;
		int          seg_len;
		int          pick;
		int          k;
		bit          full_done;
		bit          hold_done;
		logic [31:0] base0;
		logic [31:0] col;
		logic [8:0]  lim;

		rand_items = 0;
		full_done = 1'b0;
		hold_done = 1'b0;

		// Directed part: empty table, extremes of colour and index, a hit,
		// reads in and out of range, a clear, limit zero, a full table with
		// data still readable, and a limit lowered below the entries in use.
		cur_pct = 36;
		queue_job(JOB_CMD, FUNC_READ, 32'h0, 8'd0, '0);
		queue_job(JOB_CMD, FUNC_NOP, 32'hFFFF_FFFF, 8'hFF, '0);
		queue_job(JOB_CMD, FUNC_ADD, 32'h0, 8'd0, '0);
		queue_job(JOB_CMD, FUNC_ADD, 32'hFFFF_FFFF, 8'hFF, '0);
		queue_job(JOB_CMD, FUNC_ADD, 32'hFFFF_FFFF, 8'd0, '0);
		queue_job(JOB_CMD, FUNC_ADD, 32'hA5A5_5A5A, 8'd0, '0);
		queue_job(JOB_CMD, FUNC_READ, 32'h0, 8'd1, '0);
		queue_job(JOB_CMD, FUNC_READ, 32'h0, 8'd3, '0);
		queue_job(JOB_CMD, FUNC_READ, 32'h0, 8'hFF, '0);
		queue_job(JOB_CMD, FUNC_CLEAR, 32'hFFFF_FFFF, 8'hFF, '0);
		queue_job(JOB_CMD, FUNC_READ, 32'h0, 8'd0, '0);
		queue_job(JOB_CFG, FUNC_NOP, '0, '0, 9'd0);
		queue_job(JOB_CMD, FUNC_ADD, 32'h1234_5678, 8'd0, '0);
		queue_job(JOB_CMD, FUNC_ADD, 32'h1234_5678, 8'd0, '0);
		queue_job(JOB_CMD, FUNC_NOP, 32'h0, 8'd0, '0);
		queue_job(JOB_CMD, FUNC_CLEAR, 32'h0, 8'd0, '0);
		queue_job(JOB_CFG, FUNC_NOP, '0, '0, 9'd2);
		queue_job(JOB_CMD, FUNC_ADD, 32'h0000_0001, 8'd0, '0);
		queue_job(JOB_CMD, FUNC_ADD, 32'h8000_0000, 8'd0, '0);
		queue_job(JOB_CMD, FUNC_ADD, 32'h0000_0002, 8'd0, '0);
		queue_job(JOB_CMD, FUNC_READ, 32'h0, 8'd1, '0);
		queue_job(JOB_CFG, FUNC_NOP, '0, '0, 9'd1);
		queue_job(JOB_CMD, FUNC_CLEAR, 32'h0, 8'd0, '0);
		queue_job(JOB_CMD, FUNC_ADD, 32'h0000_0003, 8'd0, '0);
		queue_job(JOB_CMD, FUNC_ADD, 32'h0000_0004, 8'd0, '0);
		// The table now holds one entry under a limit of one and has overflowed.
		// The limit is raised to three and then lowered back to one; as the
		// overflow flag is sticky, every add here is ignored until a clear.
		queue_job(JOB_CFG, FUNC_NOP, '0, '0, 9'd3);
		queue_job(JOB_CMD, FUNC_ADD, 32'h0000_0004, 8'd0, '0);
		queue_job(JOB_CFG, FUNC_NOP, '0, '0, 9'd1);
		queue_job(JOB_CMD, FUNC_ADD, 32'h0000_0003, 8'd0, '0);
		queue_job(JOB_CMD, FUNC_ADD, 32'h0000_0005, 8'd0, '0);

		// Random part: segments, each under one max_colors setting and with
		// its own small pool of colours, so that hits, appends and overflow
		// all turn up often. The idle rate steps from light to heavy to none.
		while (rand_items < RANDOM_GOAL) begin
			cur_pct = (rand_items < RANDOM_GOAL / 3) ? 36 :
				(rand_items < 2 * RANDOM_GOAL / 3) ? 77 : 0;

			if (!full_done && rand_items >= 2 * RANDOM_GOAL / 3) begin
				// Fill all 256 entries, then miss once to overflow the
				// largest table. After that the last entry is read back
				// and one more add is ignored.
				full_done = 1'b1;
				queue_job(JOB_CFG, FUNC_NOP, '0, '0, 9'd256);
				queue_job(JOB_CMD, FUNC_CLEAR, $urandom, 8'($urandom), '0);
				base0 = {8'd0, 24'($urandom)};
				for (k = 0; k < 256; k++)
					queue_job(JOB_CMD, FUNC_ADD, (k == 0) ? base0 : {8'(k), 24'($urandom)},
						8'($urandom), '0);
				queue_job(JOB_CMD, FUNC_ADD, base0 ^ 32'h1, 8'd0, '0);
				queue_job(JOB_CMD, FUNC_READ, $urandom, 8'd255, '0);
				queue_job(JOB_CMD, FUNC_READ, $urandom, 8'd0, '0);
				queue_job(JOB_CMD, FUNC_ADD, base0, 8'd0, '0);
				rand_items += 261;
				continue;
			end

			// Pick a limit. The first segment takes the top of the field;
			// the others mix zero, one and small limits with values past
			// the table size.
			pick = $urandom_range(7);
			if (rand_items == 0)
				lim = 9'd511;
			else if (pick == 0)
				lim = 9'd0;
			else if (pick == 1)
				lim = 9'd1;
			else if (pick <= 4)
				lim = 9'($urandom_range(16, 2));
			else if (pick == 5)
				lim = 9'($urandom_range(511, 257));
			else
				lim = 9'($urandom_range(511));
			queue_job(JOB_CFG, FUNC_NOP, '0, '0, lim);
			// Without a clear the old entries carry over, sometimes above the new limit.
			if ($urandom_range(1) == 0)
				queue_job(JOB_CMD, FUNC_CLEAR, $urandom, 8'($urandom), '0);

			pool_n = $urandom_range(24, 1);
			for (k = 0; k < pool_n; k++) begin
				pick = $urandom_range(15);
				pool[k] = (pick == 0) ? 32'h0 : (pick == 1) ? 32'hFFFF_FFFF : $urandom;
			end

			seg_len = $urandom_range(60, 15);
			for (k = 0; k < seg_len; k++) begin
				if (!hold_done && k == 10) begin
					// Make the sender wait for every result to come back once.
					hold_done = 1'b1;
					queue_job(JOB_HOLD, FUNC_NOP, '0, '0, '0);
				end
				pick = $urandom_range(99);
				if (pick < 65) begin
					col = ($urandom_range(9) == 0) ? $urandom : pool[$urandom_range(pool_n - 1)];
					queue_job(JOB_CMD, FUNC_ADD, col, 8'($urandom), '0);
				end else if (pick < 85) begin
					queue_job(JOB_CMD, FUNC_READ, $urandom,
						($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(pool_n)), '0);
				end else if (pick < 90) begin
					queue_job(JOB_CMD, FUNC_CLEAR, $urandom, 8'($urandom), '0);
				end else begin
					queue_job(JOB_CMD, FUNC_NOP, $urandom, 8'($urandom), '0);
				end
			end
			rand_items += seg_len;
		end

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Sample at the falling edge, when all updates from the rising edge have settled.
		while (job_q.size() != 0 || start || cfg_we || beats_issued != results_seen)
			@(negedge clk);
		repeat (DRAIN_WAIT) @(negedge clk);

		$display("Ran %0d command beats: %0d adds, %0d reads, %0d clears, %0d no-ops, %0d limit writes",
			beats_issued, n_add, n_read, n_clear, n_nop, n_cfg);
		$display("Adds gave %0d hits, %0d new entries and %0d overflow answers; %0d reads missed",
			n_hit, n_append, n_ovf, n_bad_read);
		if (mismatch_cnt == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
